>>> sv/amss_pkg.sv
package amss_pkg;

   localparam int SAMPLE_W         = 14;
   localparam int MV_W             = 14;
   localparam int PROD_W           = SAMPLE_W + MV_W;
   localparam int FULL_SCALE_SHIFT = 14;
   localparam int DIGIT_W          = 4;
   localparam int NUM_DIGITS       = 4;
   localparam int SCAN_W           = 2;
   localparam int SEG_W            = 8;
   localparam int DP_BIT_POS       = 7;

   localparam logic [MV_W-1:0]  REFERENCE_RESET = 14'd3300;
   localparam logic [MV_W-1:0]  MV_LIMIT        = 14'd9999;
   localparam logic [SEG_W-1:0] BLANK_PATTERN   = 8'hFF;
   localparam logic [SEG_W-1:0] FIRST_ENABLE    = 8'h20;
   localparam logic [SEG_W-1:0] ALL_OFF         = 8'hFF;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic             valid;
      logic             tick;
      logic [MV_W-1:0]  mv;
      digits_type       digits;
   } split_type;

   function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0: p = 8'hC0;
         4'd1: p = 8'hF9;
         4'd2: p = 8'hA4;
         4'd3: p = 8'hB0;
         4'd4: p = 8'h99;
         4'd5: p = 8'h92;
         4'd6: p = 8'h82;
         4'd7: p = 8'hF8;
         4'd8: p = 8'h80;
         4'd9: p = 8'h90;
         default: p = BLANK_PATTERN;
      endcase
      return p;
   endfunction

endpackage

>>> sv/amss_scale_split.sv
module amss_scale_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [amss_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [amss_pkg::MV_W-1:0]     reference_mv,
   input  logic                          head_take,
   output amss_pkg::split_type           head
);
   import amss_pkg::*;

   logic                v1_ff, v1_in, f1_ff, f1_in;
   logic [SAMPLE_W-1:0] smp1_ff, smp1_in;
   logic                v2_ff, v2_in, f2_ff, f2_in;
   logic [PROD_W-1:0]   prod2_ff, prod2_in;
   logic                v3_ff, v3_in, f3_ff, f3_in;
   logic [MV_W-1:0]     mv3_ff, mv3_in;
   logic [DIGIT_W-1:0]  th3_ff, th3_in;
   logic [9:0]          r3_ff, r3_in;
   logic                v4_ff, v4_in, f4_ff, f4_in;
   logic [MV_W-1:0]     mv4_ff, mv4_in;
   logic [DIGIT_W-1:0]  th4_ff, th4_in, hu4_ff, hu4_in;
   logic [6:0]          r4_ff, r4_in;

   logic            go1, go2, go3, go4;
   logic [MV_W-1:0] mv_sat, r1000;
   logic [9:0]      r100;
   logic [6:0]      r10;
   logic [DIGIT_W-1:0] tens, ones;

   assign go4 = !v4_ff || head_take;
   assign go3 = !v3_ff || go4;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;
   assign req_stall = !go1;

   // scale and saturate, then strip thousands
   always_comb begin
      mv_sat = prod2_ff[PROD_W-1:FULL_SCALE_SHIFT];
      if (mv_sat > MV_LIMIT) begin
         mv_sat = MV_LIMIT;
      end
      th3_in = '0;
      r1000  = mv_sat;
      for (int i = 1; i < 10; i++) begin
         if (mv_sat >= MV_W'(i * 1000)) begin
            th3_in = DIGIT_W'(i);
            r1000  = mv_sat - MV_W'(i * 1000);
         end
      end
      mv3_in = mv_sat;
      r3_in  = r1000[9:0];
   end

   always_comb begin
      hu4_in = '0;
      r100   = r3_ff;
      for (int i = 1; i < 10; i++) begin
         if (r3_ff >= 10'(i * 100)) begin
            hu4_in = DIGIT_W'(i);
            r100   = r3_ff - 10'(i * 100);
         end
      end
      r4_in  = r100[6:0];
      mv4_in = mv3_ff;
      th4_in = th3_ff;
   end

   always_comb begin
      tens = '0;
      r10  = r4_ff;
      for (int i = 1; i < 10; i++) begin
         if (r4_ff >= 7'(i * 10)) begin
            tens = DIGIT_W'(i);
            r10  = r4_ff - 7'(i * 10);
         end
      end
      ones = r10[DIGIT_W-1:0];
   end

   always_comb begin
      head.valid  = v4_ff;
      head.tick   = f4_ff;
      head.mv     = mv4_ff;
      head.digits = {th4_ff, hu4_ff, tens, ones};
   end

   always_comb begin
      v1_in    = go1 ? req_valid : v1_ff;
      f1_in    = go1 ? req_func : f1_ff;
      smp1_in  = go1 ? req_sample : smp1_ff;
      v2_in    = go2 ? v1_ff : v2_ff;
      f2_in    = go2 ? f1_ff : f2_ff;
      prod2_in = go2 ? PROD_W'(smp1_ff) * PROD_W'(reference_mv) : prod2_ff;
      v3_in    = go3 ? v2_ff : v3_ff;
      f3_in    = go3 ? f2_ff : f3_ff;
      v4_in    = go4 ? v3_ff : v4_ff;
      f4_in    = go4 ? f3_ff : f4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
      f1_ff    <= f1_in;
      smp1_ff  <= smp1_in;
      f2_ff    <= f2_in;
      prod2_ff <= prod2_in;
      f3_ff    <= f3_in;
      f4_ff    <= f4_in;
      if (go3) begin
         mv3_ff <= mv3_in;
         th3_ff <= th3_in;
         r3_ff  <= r3_in;
      end
      if (go4) begin
         mv4_ff <= mv4_in;
         th4_ff <= th4_in;
         hu4_ff <= hu4_in;
         r4_ff  <= r4_in;
      end
   end

endmodule

>>> sv/adc_millivolt_seven_segment_scan.sv
// Millivolt readout for a four-digit multiplexed common-anode display.
// Request channel (req_valid / req_stall): req_func low carries a converter
// sample in req_sample, scaled to sample * reference / 16384 millivolts,
// saturated at 9999 and split into four decimal digits that are held.
// req_func high is a scan tick: it yields one response transaction with
// the active-low segment pattern of the current digit, its active-low
// digit enable and the held millivolt value, then advances the scan index.
// Samples yield no response. csr_write_enable loads the reference in mV.
// Each transaction passes a four-stage pipeline (input, product, thousands,
// hundreds) and then a response register, from which a tick appears on
// rsp_valid. One transaction is accepted every cycle while req_stall is
// low; a tick after a sample always shows the new value.
// Reset (synchronous): held value and digits zero, scan index zero,
// reference 3300 mV, pipeline and response register empty.
// A stalled response holds; ticks then back up in the pipeline and
// req_stall rises once it is full, while samples behind a stalled tick wait
// their turn.
module adc_millivolt_seven_segment_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [amss_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [amss_pkg::SEG_W-1:0]    rsp_segments,
   output logic [amss_pkg::SEG_W-1:0]    rsp_digit_select,
   output logic [amss_pkg::MV_W-1:0]     rsp_millivolts,
   input  logic                          csr_write_enable,
   input  logic [amss_pkg::MV_W-1:0]     csr_write_data
);
   import amss_pkg::*;

   logic [MV_W-1:0]   ref_mv_ff, ref_mv_in;
   logic [MV_W-1:0]   held_mv_ff, held_mv_in;
   digits_type        held_dig_ff, held_dig_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]  rsp_seg_ff, rsp_seg_in;
   logic [SEG_W-1:0]  rsp_sel_ff, rsp_sel_in;
   logic [MV_W-1:0]   rsp_mv_ff, rsp_mv_in;

   split_type head;
   logic      head_take;
   logic      out_move;
   logic [SEG_W-1:0] seg;

   amss_scale_split u_split (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_sample   (req_sample),
      .reference_mv (ref_mv_ff),
      .head_take    (head_take),
      .head         (head)
   );

   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign head_take = head.valid && (head.tick == FUNC_SAMPLE || out_move);

   // digits are stored thousands first, at the highest packed index
   always_comb begin
      ref_mv_in    = ref_mv_ff;
      held_mv_in   = held_mv_ff;
      held_dig_in  = held_dig_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_sel_in   = rsp_sel_ff;
      rsp_mv_in    = rsp_mv_ff;
      seg = digit_pattern(held_dig_ff[SCAN_W'(NUM_DIGITS - 1) - scan_ff]);
      if (scan_ff == '0) begin
         seg[DP_BIT_POS] = 1'b0;
      end
      if (out_move) begin
         rsp_valid_in = 1'b0;
      end
      if (head_take) begin
         if (head.tick == FUNC_TICK) begin
            rsp_valid_in = 1'b1;
            rsp_seg_in   = seg;
            rsp_sel_in   = ALL_OFF & ~(FIRST_ENABLE >> scan_ff);
            rsp_mv_in    = held_mv_ff;
            scan_in      = scan_ff + 1'b1;
         end else begin
            held_mv_in  = head.mv;
            held_dig_in = head.digits;
         end
      end
      if (csr_write_enable) begin
         ref_mv_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mv_ff    <= REFERENCE_RESET;
         held_mv_ff   <= '0;
         held_dig_ff  <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_mv_ff    <= ref_mv_in;
         held_mv_ff   <= held_mv_in;
         held_dig_ff  <= held_dig_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_seg_ff <= rsp_seg_in;
      rsp_sel_ff <= rsp_sel_in;
      rsp_mv_ff  <= rsp_mv_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segments     = rsp_seg_ff;
   assign rsp_digit_select = rsp_sel_ff;
   assign rsp_millivolts   = rsp_mv_ff;

endmodule
